FILE: hdl/first_fit_block_allocator_defines.svh
// Assertion macros used by the allocator's control module.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`define FFBA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/ffba_pkg.sv
package ffba_pkg;

   localparam int HEAP_BYTES   = 65536;
   localparam int BLOCK_BYTES  = 256;
   localparam int HDR_BYTES    = 8;
   localparam int STRIDE_BYTES = BLOCK_BYTES + HDR_BYTES;
   localparam int HEAP_WORDS   = (HEAP_BYTES + 3) / 4;
   localparam int WORD_AW      = $clog2(HEAP_WORDS);
   localparam int OFS_W        = 34;
   localparam int WANT_W       = 18;
   localparam int HSUM_W       = 18;
   localparam int POS_W        = $clog2(STRIDE_BYTES);
   localparam int SSTART_W     = $clog2(HEAP_BYTES + STRIDE_BYTES);
   localparam int CSR_ADDR_W   = 3;

   typedef logic [OFS_W-1:0]    ofs_type;
   typedef logic [WORD_AW-1:0]  word_type;
   typedef logic [WANT_W-1:0]   want_type;
   typedef logic [HSUM_W-1:0]   hsum_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [SSTART_W-1:0] sstart_type;

   localparam ofs_type    HDR_LIMIT   = ofs_type'(HEAP_BYTES - HDR_BYTES);
   localparam ofs_type    HDR_OFS     = ofs_type'(HDR_BYTES);
   localparam ofs_type    BLOCK_OFS   = ofs_type'(BLOCK_BYTES);
   localparam sstart_type INIT_LIMIT  = sstart_type'(HEAP_BYTES - STRIDE_BYTES);
   localparam sstart_type STRIDE_STEP = sstart_type'(STRIDE_BYTES);
   localparam pos_type    POS_SIZE    = pos_type'(4);
   localparam pos_type    POS_LAST    = pos_type'(STRIDE_BYTES - 4);
   localparam pos_type    POS_STEP    = pos_type'(4);
   localparam word_type   WORD_LAST   = word_type'(HEAP_WORDS - 1);
   localparam word_type   HDR_WORDS   = word_type'(HDR_BYTES / 4);
   localparam logic [31:0] BLOCK_WORD = 32'(BLOCK_BYTES);

   localparam logic [1:0] CMD_INIT  = 2'd0;
   localparam logic [1:0] CMD_ALLOC = 2'd1;
   localparam logic [1:0] CMD_FREE  = 2'd2;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT = 2'd1;
   localparam logic [1:0] STATUS_RANGE  = 2'd2;

   localparam logic CSR_IDX_HEAP_BASE = 1'b0;

   typedef struct packed {
      logic [1:0]  command;
      logic [16:0] request_bytes;
      logic [31:0] free_address;
   } req_item_type;

   typedef struct packed {
      logic [31:0] payload_address;
      logic [1:0]  status;
   } rsp_item_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      ofs_type    a;
      ofs_type    b;
      ofs_type    c;
   } alu_req_type;

   typedef struct packed {
      ofs_type result;
      logic    ge;
   } alu_rsp_type;

   typedef struct packed {
      logic        we;
      word_type    addr;
      logic [31:0] wdata;
   } mem_req_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_FITS,
      ST_A_RDSZ,
      ST_A_RDFL,
      ST_A_SURP,
      ST_A_SPLIT_AT,
      ST_A_SPLIT_W0,
      ST_A_SPLIT_W1,
      ST_A_WR_FLAG,
      ST_A_WR_SIZE,
      ST_A_ADV,
      ST_B_NEXT,
      ST_B_FITS,
      ST_B_RDSZ,
      ST_B_RDFL,
      ST_B_CMP,
      ST_B_STEP,
      ST_B_SUM,
      ST_F_OFF,
      ST_F_CHK,
      ST_F_RD
   } state_type;

endpackage

FILE: hdl/ffba_heap_ram.sv
module ffba_heap_ram (
   input  logic                   clock,
   input  ffba_pkg::mem_req_type  mem_req,
   output logic [31:0]            rdata
);

   logic [31:0] mem_ff [ffba_pkg::HEAP_WORDS];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.addr] <= mem_req.wdata;
      end
      rdata_ff <= mem_ff[mem_req.addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/ffba_alu.sv
module ffba_alu (
   input  ffba_pkg::alu_req_type alu_req,
   output ffba_pkg::alu_rsp_type alu_rsp
);

   logic [ffba_pkg::OFS_W:0] diff;
   ffba_pkg::ofs_type        sum;

   assign diff = {1'b0, alu_req.a} - {1'b0, alu_req.b};
   assign sum  = alu_req.a + alu_req.b + alu_req.c;

   always_comb begin
      case (alu_req.op)
         ffba_pkg::ALU_SUB: alu_rsp.result = diff[ffba_pkg::OFS_W-1:0];
         ffba_pkg::ALU_ADD: alu_rsp.result = sum;
         default:           alu_rsp.result = sum;
      endcase
      alu_rsp.ge = !diff[ffba_pkg::OFS_W];
   end

endmodule

FILE: hdl/ffba_ctrl.sv
`include "first_fit_block_allocator_defines.svh"

module ffba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ffba_pkg::req_item_type req_item,
   input  logic [31:0]            heap_base,
   output logic                   rsp_valid,
   output ffba_pkg::rsp_item_type rsp_item,
   output ffba_pkg::mem_req_type  mem_req,
   input  logic [31:0]            mem_rdata,
   output ffba_pkg::alu_req_type  alu_req,
   input  ffba_pkg::alu_rsp_type  alu_rsp
);

   ffba_pkg::state_type    state_ff, state_in;
   logic                   clear_cmd_ff, clear_cmd_in;
   ffba_pkg::want_type     want_ff, want_in;
   logic [31:0]            addr_ff, addr_in;
   ffba_pkg::ofs_type      at_ff, at_in;
   logic [31:0]            size_ff, size_in;
   logic [31:0]            nsize_ff, nsize_in;
   ffba_pkg::ofs_type      nxt_ff, nxt_in;
   ffba_pkg::ofs_type      total_ff, total_in;
   ffba_pkg::hsum_type     hsum_ff, hsum_in;
   ffba_pkg::ofs_type      surplus_ff, surplus_in;
   logic [31:0]            wsize_ff, wsize_in;
   ffba_pkg::ofs_type      split_ff, split_in;
   logic [31:0]            off_ff, off_in;
   ffba_pkg::word_type     word_ff, word_in;
   ffba_pkg::pos_type      pos_ff, pos_in;
   ffba_pkg::sstart_type   sstart_ff, sstart_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ffba_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffba_pkg::ST_CLEAR;
         clear_cmd_ff <= 1'b0;
         word_ff      <= '0;
         pos_ff       <= '0;
         sstart_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cmd_ff <= clear_cmd_in;
         word_ff      <= word_in;
         pos_ff       <= pos_in;
         sstart_ff    <= sstart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff     <= want_in;
      addr_ff     <= addr_in;
      at_ff       <= at_in;
      size_ff     <= size_in;
      nsize_ff    <= nsize_in;
      nxt_ff      <= nxt_in;
      total_ff    <= total_in;
      hsum_ff     <= hsum_in;
      surplus_ff  <= surplus_in;
      wsize_ff    <= wsize_in;
      split_ff    <= split_in;
      off_ff      <= off_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_comb begin
      state_in     = state_ff;
      clear_cmd_in = clear_cmd_ff;
      want_in      = want_ff;
      addr_in      = addr_ff;
      at_in        = at_ff;
      size_in      = size_ff;
      nsize_in     = nsize_ff;
      nxt_in       = nxt_ff;
      total_in     = total_ff;
      hsum_in      = hsum_ff;
      surplus_in   = surplus_ff;
      wsize_in     = wsize_ff;
      split_in     = split_ff;
      off_in       = off_ff;
      word_in      = word_ff;
      pos_in       = pos_ff;
      sstart_in    = sstart_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      mem_req      = '0;
      alu_req      = '0;
      alu_req.op   = ffba_pkg::ALU_ADD;

      case (state_ff)
         ffba_pkg::ST_CLEAR: begin
            mem_req.we   = 1'b1;
            mem_req.addr = word_ff;
            if (pos_ff == ffba_pkg::POS_SIZE && sstart_ff < ffba_pkg::INIT_LIMIT) begin
               mem_req.wdata = ffba_pkg::BLOCK_WORD;
            end
            if (pos_ff == ffba_pkg::POS_LAST) begin
               pos_in    = '0;
               sstart_in = sstart_ff + ffba_pkg::STRIDE_STEP;
            end else begin
               pos_in = pos_ff + ffba_pkg::POS_STEP;
            end
            word_in = word_ff + ffba_pkg::word_type'(1);
            if (word_ff == ffba_pkg::WORD_LAST) begin
               state_in     = ffba_pkg::ST_IDLE;
               clear_cmd_in = 1'b0;
               if (clear_cmd_ff) begin
                  rsp_valid_in                = 1'b1;
                  rsp_item_in.payload_address = '0;
                  rsp_item_in.status          = ffba_pkg::STATUS_OK;
               end
            end
         end

         ffba_pkg::ST_IDLE: begin
            if (start) begin
               addr_in = req_item.free_address;
               case (req_item.command)
                  ffba_pkg::CMD_INIT: begin
                     clear_cmd_in = 1'b1;
                     word_in      = '0;
                     pos_in       = '0;
                     sstart_in    = '0;
                     state_in     = ffba_pkg::ST_CLEAR;
                  end
                  ffba_pkg::CMD_ALLOC: begin
                     want_in = (ffba_pkg::want_type'(req_item.request_bytes)
                                + ffba_pkg::want_type'(3)) & ~ffba_pkg::want_type'(3);
                     at_in   = '0;
                     if (req_item.request_bytes == '0) begin
                        rsp_valid_in                = 1'b1;
                        rsp_item_in.payload_address = '0;
                        rsp_item_in.status          = ffba_pkg::STATUS_NO_FIT;
                     end else begin
                        state_in = ffba_pkg::ST_A_FITS;
                     end
                  end
                  ffba_pkg::CMD_FREE: begin
                     state_in = ffba_pkg::ST_F_OFF;
                  end
                  default: begin
                     rsp_valid_in                = 1'b1;
                     rsp_item_in.payload_address = '0;
                     rsp_item_in.status          = ffba_pkg::STATUS_OK;
                  end
               endcase
            end
         end

         ffba_pkg::ST_A_FITS: begin
            if (at_ff <= ffba_pkg::HDR_LIMIT) begin
               mem_req.addr = at_ff[ffba_pkg::WORD_AW+1:2] + ffba_pkg::word_type'(1);
               state_in     = ffba_pkg::ST_A_RDSZ;
            end else begin
               rsp_valid_in                = 1'b1;
               rsp_item_in.payload_address = '0;
               rsp_item_in.status          = ffba_pkg::STATUS_NO_FIT;
               state_in                    = ffba_pkg::ST_IDLE;
            end
         end

         ffba_pkg::ST_A_RDSZ: begin
            size_in      = mem_rdata;
            mem_req.addr = at_ff[ffba_pkg::WORD_AW+1:2];
            state_in     = ffba_pkg::ST_A_RDFL;
         end

         ffba_pkg::ST_A_RDFL: begin
            alu_req.op = ffba_pkg::ALU_SUB;
            alu_req.a  = ffba_pkg::ofs_type'(size_ff);
            alu_req.b  = ffba_pkg::ofs_type'(want_ff);
            if (mem_rdata[0]) begin
               state_in = ffba_pkg::ST_A_ADV;
            end else if (alu_rsp.ge) begin
               surplus_in = alu_rsp.result;
               state_in   = ffba_pkg::ST_A_SURP;
            end else begin
               state_in = ffba_pkg::ST_B_NEXT;
            end
         end

         ffba_pkg::ST_A_SURP: begin
            alu_req.op = ffba_pkg::ALU_SUB;
            alu_req.a  = surplus_ff;
            alu_req.b  = ffba_pkg::BLOCK_OFS;
            if (alu_rsp.ge) begin
               wsize_in = 32'(want_ff);
               state_in = ffba_pkg::ST_A_SPLIT_AT;
            end else begin
               wsize_in = size_ff;
               state_in = ffba_pkg::ST_A_WR_FLAG;
            end
         end

         ffba_pkg::ST_A_SPLIT_AT: begin
            alu_req.a = at_ff;
            alu_req.b = ffba_pkg::ofs_type'(want_ff);
            alu_req.c = ffba_pkg::HDR_OFS;
            split_in  = alu_rsp.result;
            state_in  = ffba_pkg::ST_A_SPLIT_W0;
         end

         ffba_pkg::ST_A_SPLIT_W0: begin
            if (split_ff <= ffba_pkg::HDR_LIMIT) begin
               mem_req.we   = 1'b1;
               mem_req.addr = split_ff[ffba_pkg::WORD_AW+1:2];
               state_in     = ffba_pkg::ST_A_SPLIT_W1;
            end else begin
               state_in = ffba_pkg::ST_A_WR_FLAG;
            end
         end

         ffba_pkg::ST_A_SPLIT_W1: begin
            alu_req.op    = ffba_pkg::ALU_SUB;
            alu_req.a     = surplus_ff;
            alu_req.b     = ffba_pkg::HDR_OFS;
            mem_req.we    = 1'b1;
            mem_req.addr  = split_ff[ffba_pkg::WORD_AW+1:2] + ffba_pkg::word_type'(1);
            mem_req.wdata = alu_rsp.result[31:0];
            state_in      = ffba_pkg::ST_A_WR_FLAG;
         end

         ffba_pkg::ST_A_WR_FLAG: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = at_ff[ffba_pkg::WORD_AW+1:2];
            mem_req.wdata = 32'd1;
            state_in      = ffba_pkg::ST_A_WR_SIZE;
         end

         ffba_pkg::ST_A_WR_SIZE: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = at_ff[ffba_pkg::WORD_AW+1:2] + ffba_pkg::word_type'(1);
            mem_req.wdata = wsize_ff;
            alu_req.a     = ffba_pkg::ofs_type'(heap_base);
            alu_req.b     = at_ff;
            alu_req.c     = ffba_pkg::HDR_OFS;
            rsp_valid_in                = 1'b1;
            rsp_item_in.payload_address = alu_rsp.result[31:0];
            rsp_item_in.status          = ffba_pkg::STATUS_OK;
            state_in                    = ffba_pkg::ST_IDLE;
         end

         ffba_pkg::ST_A_ADV: begin
            alu_req.a = at_ff;
            alu_req.b = ffba_pkg::ofs_type'(size_ff);
            alu_req.c = ffba_pkg::HDR_OFS;
            at_in     = alu_rsp.result;
            state_in  = ffba_pkg::ST_A_FITS;
         end

         ffba_pkg::ST_B_NEXT: begin
            alu_req.a = at_ff;
            alu_req.b = ffba_pkg::ofs_type'(size_ff);
            alu_req.c = ffba_pkg::HDR_OFS;
            nxt_in    = alu_rsp.result;
            total_in  = ffba_pkg::ofs_type'(size_ff);
            hsum_in   = '0;
            state_in  = ffba_pkg::ST_B_FITS;
         end

         ffba_pkg::ST_B_FITS: begin
            if (nxt_ff <= ffba_pkg::HDR_LIMIT) begin
               mem_req.addr = nxt_ff[ffba_pkg::WORD_AW+1:2] + ffba_pkg::word_type'(1);
               state_in     = ffba_pkg::ST_B_RDSZ;
            end else begin
               state_in = ffba_pkg::ST_A_ADV;
            end
         end

         ffba_pkg::ST_B_RDSZ: begin
            nsize_in     = mem_rdata;
            mem_req.addr = nxt_ff[ffba_pkg::WORD_AW+1:2];
            state_in     = ffba_pkg::ST_B_RDFL;
         end

         ffba_pkg::ST_B_RDFL: begin
            alu_req.a = total_ff;
            alu_req.b = ffba_pkg::ofs_type'(nsize_ff);
            if (mem_rdata[0]) begin
               state_in = ffba_pkg::ST_A_ADV;
            end else begin
               total_in = alu_rsp.result;
               hsum_in  = hsum_ff + ffba_pkg::hsum_type'(ffba_pkg::HDR_BYTES);
               state_in = ffba_pkg::ST_B_CMP;
            end
         end

         ffba_pkg::ST_B_CMP: begin
            alu_req.op = ffba_pkg::ALU_SUB;
            alu_req.a  = total_ff;
            alu_req.b  = ffba_pkg::ofs_type'(want_ff);
            if (alu_rsp.ge) begin
               state_in = ffba_pkg::ST_B_SUM;
            end else begin
               state_in = ffba_pkg::ST_B_STEP;
            end
         end

         ffba_pkg::ST_B_STEP: begin
            alu_req.a = nxt_ff;
            alu_req.b = ffba_pkg::ofs_type'(nsize_ff);
            alu_req.c = ffba_pkg::HDR_OFS;
            nxt_in    = alu_rsp.result;
            state_in  = ffba_pkg::ST_B_FITS;
         end

         ffba_pkg::ST_B_SUM: begin
            alu_req.a = total_ff;
            alu_req.b = ffba_pkg::ofs_type'(hsum_ff);
            wsize_in  = alu_rsp.result[31:0];
            state_in  = ffba_pkg::ST_A_WR_FLAG;
         end

         ffba_pkg::ST_F_OFF: begin
            alu_req.op = ffba_pkg::ALU_SUB;
            alu_req.a  = ffba_pkg::ofs_type'(addr_ff);
            alu_req.b  = ffba_pkg::ofs_type'(heap_base);
            off_in     = alu_rsp.result[31:0];
            if (addr_ff == '0) begin
               rsp_valid_in                = 1'b1;
               rsp_item_in.payload_address = '0;
               rsp_item_in.status          = ffba_pkg::STATUS_OK;
               state_in                    = ffba_pkg::ST_IDLE;
            end else begin
               state_in = ffba_pkg::ST_F_CHK;
            end
         end

         ffba_pkg::ST_F_CHK: begin
            if (off_ff < 32'(ffba_pkg::HDR_BYTES) || off_ff >= 32'(ffba_pkg::HEAP_BYTES)) begin
               rsp_valid_in                = 1'b1;
               rsp_item_in.payload_address = '0;
               rsp_item_in.status          = ffba_pkg::STATUS_RANGE;
               state_in                    = ffba_pkg::ST_IDLE;
            end else begin
               mem_req.addr = off_ff[ffba_pkg::WORD_AW+1:2] - ffba_pkg::HDR_WORDS;
               state_in     = ffba_pkg::ST_F_RD;
            end
         end

         ffba_pkg::ST_F_RD: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = off_ff[ffba_pkg::WORD_AW+1:2] - ffba_pkg::HDR_WORDS;
            mem_req.wdata = mem_rdata & ~32'd1;
            rsp_valid_in                = 1'b1;
            rsp_item_in.payload_address = '0;
            rsp_item_in.status          = ffba_pkg::STATUS_OK;
            state_in                    = ffba_pkg::ST_IDLE;
         end

         default: begin
            state_in = ffba_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = state_ff != ffba_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `FFBA_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid_ff && !start,
      !rsp_valid_ff, "result strobe held without a new item")
   `FFBA_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_valid_ff,
      state_ff == ffba_pkg::ST_IDLE, "result shown while a command is still running")
   `FFBA_ASSERT_SAME(a_fail_zero, clock, reset,
      rsp_valid_ff && rsp_item_ff.status != ffba_pkg::STATUS_OK,
      rsp_item_ff.payload_address == '0, "failed command returned a nonzero address")
   `FFBA_ASSERT_NEXT(a_start_busy, clock, reset, start && state_ff == ffba_pkg::ST_IDLE,
      state_ff != ffba_pkg::ST_IDLE || rsp_valid_ff, "accepted item neither started nor answered")
   `FFBA_ASSERT_SAME(a_hdr_inside, clock, reset, state_ff == ffba_pkg::ST_A_RDSZ,
      at_ff <= ffba_pkg::HDR_LIMIT, "header read beyond the heap end")

endmodule

FILE: hdl/first_fit_block_allocator.sv
// First-fit heap allocator with 8-byte block headers kept in a single-port 16384-word
// memory. After reset the block runs a clearing pass that lays out the initial free
// headers and holds busy high meanwhile; an initialize command repeats that pass and
// answers after it. An allocate reads each header that it visits word by word through
// the one memory port, may absorb following free blocks, and then writes the headers
// and answers; its block-size arithmetic goes through one shared adder. Each item gives
// exactly one result on rsp_item, shown with rsp_valid for a single cycle; it cannot be
// held off, so the receiver must take it then.
module first_fit_block_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ffba_pkg::req_item_type            req_item,
   output logic                              rsp_valid,
   output ffba_pkg::rsp_item_type            rsp_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ffba_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   logic [31:0]           heap_base_ff, heap_base_in;
   ffba_pkg::mem_req_type mem_req;
   logic [31:0]           mem_rdata;
   ffba_pkg::alu_req_type alu_req;
   ffba_pkg::alu_rsp_type alu_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
      end else begin
         heap_base_ff <= heap_base_in;
      end
   end

   always_comb begin
      heap_base_in = heap_base_ff;
      if (psel && penable && pwrite && paddr[2] == ffba_pkg::CSR_IDX_HEAP_BASE) begin
         heap_base_in = pwdata;
      end
      prdata = (paddr[2] == ffba_pkg::CSR_IDX_HEAP_BASE) ? heap_base_ff : '0;
   end

   assign pready = 1'b1;

   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .heap_base (heap_base_ff),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata),
      .alu_req   (alu_req),
      .alu_rsp   (alu_rsp)
   );

   ffba_heap_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   ffba_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

endmodule
